// ===== src/lrat_pkg.sv =====
// ----------------------------------------------------------------------------
// lrat_pkg
// Shared types and constants of the lazy range-add maximum tree core.
// ----------------------------------------------------------------------------
package lrat_pkg;

  localparam int unsigned MaxLeavesDefault = 1024;
  localparam int unsigned ValueBitsDefault = 32;
  localparam int unsigned CfgBits          = 11;
  localparam int unsigned PosBits          = 11;
  localparam int unsigned DeltaBits        = 32;
  localparam int unsigned OutBits          = 32;
  localparam logic [CfgBits-1:0] LeafCountReset = 11'd1024;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_VISIT,
    ST_APPLY,
    ST_PD0,
    ST_PD1,
    ST_PD2,
    ST_DESC,
    ST_RET,
    ST_POST0,
    ST_POST1,
    ST_POST2,
    ST_OUT
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CFG,
    CMD_LOAD,
    CMD_CLR_STEP,
    CMD_START,
    CMD_RD_NODE,
    CMD_APPLY,
    CMD_PD0,
    CMD_PD1,
    CMD_PD2,
    CMD_DESC,
    CMD_RET,
    CMD_POST0,
    CMD_POST1,
    CMD_POST2,
    CMD_OUT
  } cmd_e;

  typedef struct packed {
    logic clr_done;
    logic item_clear;
    logic empty;
    logic full_cover;
    logic sp_zero;
    logic ret_right;
    logic out_free;
  } status_t;

endpackage

// ===== src/lrat_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrat_ctrl
// Sequencer that walks the tree update and issues datapath commands.
// ----------------------------------------------------------------------------
module lrat_ctrl
  import lrat_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cfg_we_i,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_e    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE) && !cfg_we_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_done) begin
          state_d = status_i.item_clear ? ST_OUT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cfg_we_i) begin
          state_d = ST_CLEAR;
        end else if (in_valid_i) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        if (status_i.item_clear) begin
          state_d = ST_CLEAR;
        end else if (status_i.empty) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_VISIT;
        end
      end
      ST_VISIT: state_d = status_i.full_cover ? ST_APPLY : ST_PD0;
      ST_APPLY: state_d = ST_RET;
      ST_PD0:   state_d = ST_PD1;
      ST_PD1:   state_d = ST_PD2;
      ST_PD2:   state_d = ST_DESC;
      ST_DESC:  state_d = ST_VISIT;
      ST_RET: begin
        if (status_i.sp_zero) begin
          state_d = ST_OUT;
        end else if (status_i.ret_right) begin
          state_d = ST_VISIT;
        end else begin
          state_d = ST_POST0;
        end
      end
      ST_POST0: state_d = ST_POST1;
      ST_POST1: state_d = ST_POST2;
      ST_POST2: state_d = ST_RET;
      ST_OUT: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = CMD_NONE;
    unique case (state_q)
      ST_CLEAR: cmd_o = CMD_CLR_STEP;
      ST_IDLE: begin
        if (cfg_we_i) begin
          cmd_o = CMD_CFG;
        end else if (in_valid_i) begin
          cmd_o = CMD_LOAD;
        end
      end
      ST_START: begin
        if (!status_i.item_clear && !status_i.empty) begin
          cmd_o = CMD_START;
        end
      end
      ST_VISIT: cmd_o = CMD_RD_NODE;
      ST_APPLY: cmd_o = CMD_APPLY;
      ST_PD0:   cmd_o = CMD_PD0;
      ST_PD1:   cmd_o = CMD_PD1;
      ST_PD2:   cmd_o = CMD_PD2;
      ST_DESC:  cmd_o = CMD_DESC;
      ST_RET:   cmd_o = CMD_RET;
      ST_POST0: cmd_o = CMD_POST0;
      ST_POST1: cmd_o = CMD_POST1;
      ST_POST2: cmd_o = CMD_POST2;
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o = CMD_OUT;
        end
      end
      default: cmd_o = CMD_NONE;
    endcase
  end

endmodule

// ===== src/lrat_dpath.sv =====
// ----------------------------------------------------------------------------
// lrat_dpath
// Node memory, traversal stack, item registers and output register.
// ----------------------------------------------------------------------------
module lrat_dpath
  import lrat_pkg::*;
#(
  parameter int unsigned MaxLeaves = MaxLeavesDefault,
  parameter int unsigned ValueBits = ValueBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_e                 cmd_i,
  output status_t              status_o,
  input  logic [CfgBits-1:0]   cfg_wdata_i,
  input  logic                 func_i,
  input  logic [PosBits-1:0]   range_left_i,
  input  logic [PosBits-1:0]   range_right_i,
  input  logic signed [DeltaBits-1:0] delta_i,
  input  logic                 column_end_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OutBits-1:0]   global_max_o,
  output logic [OutBits-1:0]   best_o
);

  localparam int unsigned LW    = $clog2(MaxLeaves + 1);
  localparam int unsigned CW    = (LW > CfgBits) ? LW : CfgBits;
  localparam int unsigned Nodes = 4 * MaxLeaves;
  localparam int unsigned NW    = $clog2(Nodes);
  localparam int unsigned SD    = $clog2(MaxLeaves) + 1;
  localparam int unsigned SPW   = $clog2(SD + 1);
  localparam int unsigned IW    = $clog2(SD);
  localparam int unsigned VB    = ValueBits;

  logic [CfgBits-1:0] leaf_q;
  logic               clr_item_q, empty_q, col_q;
  logic [LW-1:0]      ql_q, qr_q;
  logic [VB-1:0]      d_q, p_q, lmax_q, root_q, best_q;
  logic [NW-1:0]      cur_node_q, clr_addr_q;
  logic [LW-1:0]      cur_lo_q, cur_hi_q;
  logic [SPW-1:0]     sp_q;
  logic [NW-1:0]      stk_node_q [SD];
  logic [LW-1:0]      stk_lo_q   [SD];
  logic [LW-1:0]      stk_hi_q   [SD];
  logic               stk_right_q [SD];
  logic [2*VB-1:0]    mem_q [Nodes];
  logic [2*VB-1:0]    rdata_q;
  logic               out_valid_q;
  logic [OutBits-1:0] gmax_out_q, best_out_q;

  logic [CW-1:0]   lcx, n_c, qlx, qrx;
  logic [LW-1:0]   n_leaves;
  logic [LW:0]     sum_c, top_sum_c;
  logic [LW-1:0]   mid_c, top_mid_c;
  logic [NW-1:0]   lc_c, rc_c;
  logic [IW-1:0]   push_idx, top_idx;
  logic [SPW-1:0]  sp_m1;
  logic [VB-1:0]   rmax, rpend, best_new;
  logic            we;
  logic [NW-1:0]   waddr, raddr;
  logic [2*VB-1:0] wdata;
  logic [63:0]     dx, rz, bz;

  always_comb begin
    lcx = CW'(leaf_q);
    if (lcx == '0) begin
      n_c = CW'(1);
    end else if (lcx > CW'(MaxLeaves)) begin
      n_c = CW'(MaxLeaves);
    end else begin
      n_c = lcx;
    end
    n_leaves = n_c[LW-1:0];
    qlx = CW'(range_left_i);
    if (qlx == '0) begin
      qlx = CW'(1);
    end
    qrx = CW'(range_right_i);
    if (qrx > n_c) begin
      qrx = n_c;
    end
    dx = 64'(delta_i);
  end

  assign sum_c  = {1'b0, cur_lo_q} + {1'b0, cur_hi_q};
  assign mid_c  = sum_c[LW:1];
  assign lc_c   = {cur_node_q[NW-2:0], 1'b0};
  assign rc_c   = {cur_node_q[NW-2:0], 1'b1};
  assign sp_m1  = sp_q - 1'b1;
  assign push_idx = sp_q[IW-1:0];
  assign top_idx  = sp_m1[IW-1:0];
  assign top_sum_c = {1'b0, stk_lo_q[top_idx]} + {1'b0, stk_hi_q[top_idx]};
  assign top_mid_c = top_sum_c[LW:1];
  assign rmax  = rdata_q[2*VB-1:VB];
  assign rpend = rdata_q[VB-1:0];
  assign best_new = (col_q && ($signed(root_q) > $signed(best_q))) ? root_q : best_q;
  assign rz = 64'(root_q);
  assign bz = 64'(best_new);

  always_comb begin
    status_o.clr_done   = (clr_addr_q == NW'(Nodes - 1));
    status_o.item_clear = clr_item_q;
    status_o.empty      = empty_q;
    status_o.full_cover = (ql_q <= cur_lo_q) && (cur_hi_q <= qr_q);
    status_o.sp_zero    = (sp_q == '0);
    status_o.ret_right  = !stk_right_q[top_idx] && (top_mid_c < qr_q);
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_comb begin
    we    = 1'b0;
    waddr = cur_node_q;
    wdata = '0;
    raddr = cur_node_q;
    unique case (cmd_i)
      CMD_CLR_STEP: begin
        we    = 1'b1;
        waddr = clr_addr_q;
      end
      CMD_APPLY: begin
        we    = 1'b1;
        wdata = {rmax + d_q, rpend + d_q};
      end
      CMD_PD0: raddr = lc_c;
      CMD_PD1: begin
        we    = 1'b1;
        waddr = lc_c;
        wdata = {rmax + p_q, rpend + p_q};
        raddr = rc_c;
      end
      CMD_PD2: begin
        we    = 1'b1;
        waddr = rc_c;
        wdata = {rmax + p_q, rpend + p_q};
      end
      CMD_POST0: raddr = lc_c;
      CMD_POST1: raddr = rc_c;
      CMD_POST2: begin
        we    = 1'b1;
        wdata = {(($signed(rmax) > $signed(lmax_q)) ? rmax : lmax_q), {VB{1'b0}}};
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leaf_q      <= LeafCountReset;
      clr_item_q  <= 1'b0;
      clr_addr_q  <= '0;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
      root_q      <= '0;
      best_q      <= '0;
    end else begin
      if (cmd_i == CMD_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (we && (waddr == NW'(1))) begin
        root_q <= wdata[2*VB-1:VB];
      end
      unique case (cmd_i)
        CMD_CFG: begin
          leaf_q     <= cfg_wdata_i;
          clr_item_q <= 1'b0;
          clr_addr_q <= '0;
        end
        CMD_LOAD: begin
          clr_item_q <= func_i;
          clr_addr_q <= '0;
        end
        CMD_CLR_STEP: begin
          clr_addr_q <= clr_addr_q + 1'b1;
          best_q     <= '0;
        end
        CMD_START: sp_q <= '0;
        CMD_DESC: sp_q <= sp_q + 1'b1;
        CMD_RET: begin
          if ((sp_q != '0) && !status_o.ret_right) begin
            sp_q <= sp_m1;
          end
        end
        CMD_OUT: begin
          best_q <= best_new;
        end
        default: sp_q <= sp_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      CMD_LOAD: begin
        ql_q    <= qlx[LW-1:0];
        qr_q    <= qrx[LW-1:0];
        empty_q <= qlx > qrx;
        d_q     <= dx[VB-1:0];
        col_q   <= column_end_i;
      end
      CMD_START: begin
        cur_node_q <= NW'(1);
        cur_lo_q   <= LW'(1);
        cur_hi_q   <= n_leaves;
      end
      CMD_PD0: p_q <= rpend;
      CMD_POST1: lmax_q <= rmax;
      CMD_DESC: begin
        stk_node_q[push_idx] <= cur_node_q;
        stk_lo_q[push_idx]   <= cur_lo_q;
        stk_hi_q[push_idx]   <= cur_hi_q;
        if (ql_q <= mid_c) begin
          stk_right_q[push_idx] <= 1'b0;
          cur_node_q <= lc_c;
          cur_hi_q   <= mid_c;
        end else begin
          stk_right_q[push_idx] <= 1'b1;
          cur_node_q <= rc_c;
          cur_lo_q   <= mid_c + 1'b1;
        end
      end
      CMD_RET: begin
        if (sp_q != '0) begin
          if (status_o.ret_right) begin
            stk_right_q[top_idx] <= 1'b1;
            cur_node_q <= {stk_node_q[top_idx][NW-2:0], 1'b1};
            cur_lo_q   <= top_mid_c + 1'b1;
            cur_hi_q   <= stk_hi_q[top_idx];
          end else begin
            cur_node_q <= stk_node_q[top_idx];
            cur_lo_q   <= stk_lo_q[top_idx];
            cur_hi_q   <= stk_hi_q[top_idx];
          end
        end
      end
      CMD_OUT: begin
        gmax_out_q <= rz[OutBits-1:0];
        best_out_q <= bz[OutBits-1:0];
      end
      default: p_q <= p_q;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign global_max_o = gmax_out_q;
  assign best_o       = best_out_q;

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(SD)) else $error("traversal stack overflow");

  a_visit_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_RD_NODE) |-> (cur_lo_q <= cur_hi_q))
    else $error("visited node has an empty span");

  a_desc_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_DESC) |-> ((ql_q <= mid_c) || (mid_c < qr_q)))
    else $error("descent into a node with no overlap");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_OUT) |-> (!out_valid_q || out_ready_i))
    else $error("result overwrites an untaken result");

endmodule

// ===== src/lazy_range_add_max_tree_core.sv =====
// ----------------------------------------------------------------------------
// lazy_range_add_max_tree_core
// Segment tree with lazy range add and global maximum over signed values.
// ----------------------------------------------------------------------------
// Each input transfer either clears the tree or adds delta to every leaf of a
// range, and yields one result with the root maximum and the running best.
// Items are handled one at a time on a node memory with one read and one
// write port: a fully covered node is read and takes the add in place, and a
// partly covered node adds a push-down of its pending add, descent, the turn
// to its right child and the re-merge of its children. A range add over the
// whole tree touches only the root, and an empty range visits no node.
// After reset, after a leaf_count write and for every clear item, a clearing
// pass writes all 4 * MAX_LEAVES nodes, one a cycle, with no input accepted.
module lazy_range_add_max_tree_core
  import lrat_pkg::*;
#(
  parameter int unsigned MAX_LEAVES = MaxLeavesDefault,
  parameter int unsigned VALUE_BITS = ValueBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgBits-1:0] cfg_wdata_i,   // leaf_count
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [55:0]        s_axis_tdata,  // range_left, range_right, delta
  input  logic [0:0]         s_axis_tuser,  // func
  input  logic               s_axis_tlast,  // column_end
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [63:0]        m_axis_tdata   // global_max, best
);

  cmd_e    cmd;
  status_t status;

  lrat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lrat_dpath #(
    .MaxLeaves (MAX_LEAVES),
    .ValueBits (VALUE_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_wdata_i   (cfg_wdata_i),
    .func_i        (s_axis_tuser[0]),
    .range_left_i  (s_axis_tdata[10:0]),
    .range_right_i (s_axis_tdata[21:11]),
    .delta_i       (s_axis_tdata[53:22]),
    .column_end_i  (s_axis_tlast),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .global_max_o  (m_axis_tdata[31:0]),
    .best_o        (m_axis_tdata[63:32])
  );

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the lazy range-add maximum tree core.
// ----------------------------------------------------------------------------
// A directed table and then random range adds and clears run over several
// leaf counts, among them the extremes. A segment tree model in the bench
// predicts the root maximum and the running best of every transfer. The
// input side idles and the output side stalls at random in several phases.
// ----------------------------------------------------------------------------
module tb
  import lrat_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Nodes = 4 * MaxLeavesDefault;
  localparam bit FnAdd = 1'b0;
  localparam bit FnClear = 1'b1;

  typedef struct {
    bit        func;
    bit [10:0] ql;
    bit [10:0] qr;
    bit [31:0] delta;
    bit        col;
    bit        typed;
    bit [31:0] exp_max;
    bit [31:0] exp_best;
  } item_t;

  typedef struct {
    bit [31:0] gmax;
    bit [31:0] best;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgBits-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;

  lazy_range_add_max_tree_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  bit [31:0] node_max_m[Nodes];
  bit [31:0] node_pend_m[Nodes];
  bit [31:0] best_m;
  int unsigned leaves_m;
  result_t pending_results[$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_clears = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;

  item_t dir_rows[17] = '{
    '{FnAdd, 11'd1, 11'd1024, 32'd5, 1'b1, 1'b1, 32'd5, 32'd5},
    '{FnAdd, 11'd1, 11'd1024, 32'h8000_0000, 1'b0, 1'b1, 32'h8000_0005, 32'd5},
    '{FnClear, 11'd7, 11'd9, 32'd77, 1'b1, 1'b1, 32'd0, 32'd0},
    '{FnAdd, 11'd1, 11'd1024, 32'h7fff_ffff, 1'b1, 1'b1, 32'h7fff_ffff, 32'h7fff_ffff},
    '{FnAdd, 11'd1, 11'd1, 32'd1, 1'b0, 1'b0, 0, 0},
    '{FnAdd, 11'd1024, 11'd1024, 32'd1, 1'b1, 1'b0, 0, 0},
    '{FnAdd, 11'd10, 11'd9, 32'd99, 1'b0, 1'b0, 0, 0},
    '{FnAdd, 11'd0, 11'd2047, 32'hffff_ffff, 1'b0, 1'b0, 0, 0},
    '{FnAdd, 11'd2047, 11'd2047, 32'd3, 1'b0, 1'b0, 0, 0},
    '{FnAdd, 11'd512, 11'd513, 32'hffff_fff9, 1'b1, 1'b0, 0, 0},
    '{FnClear, 11'd0, 11'd0, 32'd0, 1'b0, 1'b1, 32'd0, 32'd0},
    '{FnAdd, 11'd1, 11'd1024, 32'hffff_ffff, 1'b1, 1'b1, 32'hffff_ffff, 32'd0},
    '{FnAdd, 11'd3, 11'd700, 32'h1234_5678, 1'b1, 1'b0, 0, 0},
    '{FnAdd, 11'd1, 11'd1024, 32'h7fff_ffff, 1'b0, 1'b0, 0, 0},
    '{FnClear, 11'd2047, 11'd2047, 32'hffff_ffff, 1'b1, 1'b1, 32'd0, 32'd0},
    '{FnAdd, 11'd1, 11'd1024, 32'h7fff_ffff, 1'b1, 1'b0, 0, 0},
    '{FnAdd, 11'd1, 11'd1024, 32'h7fff_ffff, 1'b1, 1'b0, 0, 0}
  };

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void tree_clear();
    foreach (node_max_m[i]) begin
      node_max_m[i] = '0;
      node_pend_m[i] = '0;
    end
    best_m = '0;
  endfunction

  function automatic void node_add(int nd, bit [31:0] d);
    if (nd < Nodes) begin
      node_max_m[nd] += d;
      node_pend_m[nd] += d;
    end
  endfunction

  function automatic void tree_range_add(int nd, int lo, int hi, int ql, int qr, bit [31:0] d);
    int mid;
    if (nd >= Nodes) return;
    if (ql <= lo && hi <= qr) begin
      node_add(nd, d);
      return;
    end
    if (2 * nd + 1 >= Nodes) return;
    node_add(2 * nd, node_pend_m[nd]);
    node_add(2 * nd + 1, node_pend_m[nd]);
    node_pend_m[nd] = '0;
    mid = (lo + hi) >> 1;
    if (ql <= mid) tree_range_add(2 * nd, lo, mid, ql, qr, d);
    if (mid < qr) tree_range_add(2 * nd + 1, mid + 1, hi, ql, qr, d);
    node_max_m[nd] = ($signed(node_max_m[2 * nd + 1]) > $signed(node_max_m[2 * nd]))
                     ? node_max_m[2 * nd + 1] : node_max_m[2 * nd];
  endfunction

  function automatic void set_leaves(bit [10:0] v);
    leaves_m = (v == 0) ? 1 : (v > MaxLeavesDefault) ? MaxLeavesDefault : v;
    tree_clear();
  endfunction

  function automatic result_t predict_tree(item_t it);
    result_t r;
    int ql;
    int qr;
    if (it.func == FnClear) begin
      tree_clear();
    end else begin
      ql = (it.ql < 1) ? 1 : it.ql;
      qr = (it.qr > leaves_m) ? leaves_m : it.qr;
      if (ql <= qr) tree_range_add(1, 1, leaves_m, ql, qr, it.delta);
    end
    if (it.col && $signed(node_max_m[1]) > $signed(best_m)) best_m = node_max_m[1];
    r.gmax = node_max_m[1];
    r.best = best_m;
    return r;
  endfunction

  task automatic send_item(item_t it);
    result_t r;
    int gap;
    gap = 0;
    if (send_idle_pct > 0)
      while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, it.delta, it.qr, it.ql};
    s_axis_tuser <= it.func;
    s_axis_tlast <= it.col;
    do @(posedge clk_i); while (!s_axis_tready);
    r = predict_tree(it);
    if (it.typed) begin
      r.gmax = it.exp_max;
      r.best = it.exp_best;
    end
    pending_results.insert(pending_results.size(), r);
    n_items++;
    if (it.func == FnClear) n_clears++;
  endtask

  function automatic bit [31:0] rand_delta();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom();
      3: return 32'h4000_0000 + $urandom_range(16);
      default: return $urandom_range(200) - 100;
    endcase
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int k;
    it.typed = 1'b0;
    it.func = ($urandom_range(99) < 2) ? FnClear : FnAdd;
    it.delta = rand_delta();
    it.col = 1'($urandom_range(1));
    k = $urandom_range(99);
    if (k < 85) begin
      it.ql = 11'($urandom_range(leaves_m, 1));
      it.qr = 11'($urandom_range(leaves_m, it.ql));
    end else if (k < 95) begin
      it.ql = 11'($urandom_range(2047));
      it.qr = 11'($urandom_range(2047));
    end else begin
      it.ql = 11'($urandom_range(leaves_m, 1) + 1);
      it.qr = 11'(it.ql - 1 - $urandom_range(1));
    end
    return it;
  endfunction

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_leaves(bit [10:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    set_leaves(v);
  endtask

  // Receiver side, with an optional long hold-off to back up the input.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && hold == 0) hold = 3000;
      if (hold > 0) begin
        hold--;
        if (hold == 0) hold_req = 1'b0;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_axis_tdata);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (m_axis_tdata[31:0] !== e.gmax) begin
          $display("%0t: global_max expected %h actual %h", $time, e.gmax,
                   m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tdata[63:32] !== e.best) begin
          $display("%0t: best expected %h actual %h", $time, e.best,
                   m_axis_tdata[63:32]);
          errors++;
        end
      end
    end
  end

  initial begin
    bit [10:0] leaf_set[8] = '{11'd1024, 11'd1, 11'd0, 11'd2047, 11'd2, 11'd17,
                               11'd300, 11'd1024};
    int idle_s[8] = '{0, 69, 0, 34, 69, 0, 34, 0};
    int idle_r[8] = '{0, 0, 69, 34, 69, 0, 34, 69};
    set_leaves(LeafCountReset);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) begin
        wait_drained();
        write_leaves(leaf_set[ph]);
      end
      send_idle_pct = idle_s[ph];
      recv_stall_pct = idle_r[ph];
      if (ph == 0) foreach (dir_rows[i]) send_item(dir_rows[i]);
      if (ph == 5) hold_req = 1'b1;
      for (int i = 0; i < 190; i++) send_item(rand_item());
    end
    wait_drained();
    repeat (100) @(posedge clk_i);
    $display("Sent %0d items (%0d clears) over 8 leaf counts; %0d results checked.",
             n_items, n_clears, n_results);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
